FILE: hdl/epc_pkg.sv
package epc_pkg;

  localparam int EPC_COORD_BITS     = 16;
  localparam int EPC_TRIG_FRAC_BITS = 14;
  localparam int TOL_BITS           = 16;
  localparam int APB_AW             = 5;
  localparam int APB_DW             = 32;

  typedef enum logic [2:0] {
    REG_SEMI_MAJOR = 3'd0,
    REG_SEMI_MINOR = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_COS_TILT   = 3'd4,
    REG_SIN_TILT   = 3'd5,
    REG_TOLERANCE  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    POS_INTERIOR = 2'd0,
    POS_BOUNDARY = 2'd1,
    POS_EXTERIOR = 2'd2
  } pos_t;

endpackage

FILE: hdl/ellipse_point_classifier.sv
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_point_x, in_point_y
// out       out_valid / out_ready     out_position
// config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// Eight register stages from accepted word to result; one word per cycle unless stalled.
// The depth is set by the chain subtract, rotate, sum, square, scale, sum, offset, compare.
// rst_n clears the stage valid bits and loads the register reset values.
// A stalled output freezes every stage together; in_ready drops only while a result waits.
module ellipse_point_classifier
  import epc_pkg::*;
#(
  parameter int COORD_BITS     = EPC_COORD_BITS,
  parameter int TRIG_FRAC_BITS = EPC_TRIG_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_position,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int CB    = COORD_BITS;
  localparam int FB    = TRIG_FRAC_BITS;
  localparam int TW    = FB + 2;
  localparam int DX_W  = CB + 1;
  localparam int PW    = DX_W + TW;
  localparam int UW    = PW + 1;
  localparam int SQ_W  = 2 * PW - 1;
  localparam int LO_W  = SQ_W / 2;
  localparam int HI_W  = SQ_W - LO_W;
  localparam int A_W   = 2 * CB;
  localparam int PP_W  = HI_W + A_W;
  localparam int L_W   = SQ_W + A_W + 1;
  localparam int K_W   = 2 * A_W;
  localparam int KT_W  = A_W + TOL_BITS;
  localparam int T_W   = K_W + TOL_BITS + 2 * FB;
  localparam int LS_W  = L_W + TOL_BITS;
  localparam int D_W   = ((LS_W > T_W) ? LS_W : T_W) + 1;
  localparam int NSTG  = 8;

  // configuration registers
  logic [CB-1:0]       semi_major_r, semi_minor_r;
  logic [CB-1:0]       center_x_r, center_y_r;
  logic [TW-1:0]       cos_r, sin_r;
  logic [TOL_BITS-1:0] tol_r;
  logic                wr_en;
  reg_idx_t            reg_idx;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_major_r <= CB'(1);
      semi_minor_r <= CB'(1);
      center_x_r   <= '0;
      center_y_r   <= '0;
      cos_r        <= TW'(1) << FB;
      sin_r        <= '0;
      tol_r        <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SEMI_MAJOR: semi_major_r <= pwdata[CB-1:0];
        REG_SEMI_MINOR: semi_minor_r <= pwdata[CB-1:0];
        REG_CENTER_X:   center_x_r   <= pwdata[CB-1:0];
        REG_CENTER_Y:   center_y_r   <= pwdata[CB-1:0];
        REG_COS_TILT:   cos_r        <= pwdata[TW-1:0];
        REG_SIN_TILT:   sin_r        <= pwdata[TW-1:0];
        REG_TOLERANCE:  tol_r        <= pwdata[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SEMI_MAJOR: prdata = APB_DW'(semi_major_r);
      REG_SEMI_MINOR: prdata = APB_DW'(semi_minor_r);
      REG_CENTER_X:   prdata = APB_DW'(center_x_r);
      REG_CENTER_Y:   prdata = APB_DW'(center_y_r);
      REG_COS_TILT:   prdata = APB_DW'(cos_r);
      REG_SIN_TILT:   prdata = APB_DW'(sin_r);
      REG_TOLERANCE:  prdata = APB_DW'(tol_r);
      default:        prdata = '0;
    endcase
  end

  // terms derived from the configuration, registered; words are not held while they settle
  logic [CB-1:0]   a_eff, b_eff;
  logic [A_W-1:0]  a2_r, b2_r;
  logic [K_W-1:0]  k_r;
  logic [KT_W-1:0] kt_lo_r, kt_hi_r;
  logic [D_W-1:0]  thr_r, nthr_r;

  assign a_eff = (semi_major_r == '0) ? CB'(1) : semi_major_r;
  assign b_eff = (semi_minor_r == '0) ? CB'(1) : semi_minor_r;

  always_ff @(posedge clk) begin
    a2_r    <= A_W'(a_eff) * A_W'(a_eff);
    b2_r    <= A_W'(b_eff) * A_W'(b_eff);
    k_r     <= K_W'(a2_r) * K_W'(b2_r);
    kt_lo_r <= KT_W'(k_r[A_W-1:0]) * KT_W'(tol_r);
    kt_hi_r <= KT_W'(k_r[K_W-1:A_W]) * KT_W'(tol_r);
    thr_r   <= (D_W'(kt_hi_r) << (A_W + 2 * FB)) + (D_W'(kt_lo_r) << (2 * FB));
    nthr_r  <= D_W'(0) - thr_r;
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic            en;

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // datapath
  logic signed [DX_W-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [PW-1:0]   xc_nxt, ys_nxt, yc_nxt, xs_nxt;
  logic signed [PW-1:0]   xc_r, ys_r, yc_r, xs_r;
  logic signed [UW-1:0]   u_nxt, v_nxt, u_r, v_r;
  logic signed [2*UW-1:0] usq_full, vsq_full;
  logic [SQ_W-1:0]        usq_nxt, vsq_nxt, usq_r, vsq_r;
  logic [PP_W-1:0]        ulo_nxt, uhi_nxt, vlo_nxt, vhi_nxt;
  logic [PP_W-1:0]        ulo_r, uhi_r, vlo_r, vhi_r;
  logic [L_W-1:0]         l_nxt, l_r;
  logic [D_W-1:0]         d_nxt, d_r;
  logic [1:0]             pos_nxt, pos_r;

  always_comb begin
    dx_nxt   = {in_point_x[CB-1], in_point_x} - {center_x_r[CB-1], center_x_r};
    dy_nxt   = {in_point_y[CB-1], in_point_y} - {center_y_r[CB-1], center_y_r};
    xc_nxt   = dx_r * $signed(cos_r);
    ys_nxt   = dy_r * $signed(sin_r);
    yc_nxt   = dy_r * $signed(cos_r);
    xs_nxt   = dx_r * $signed(sin_r);
    u_nxt    = {xc_r[PW-1], xc_r} + {ys_r[PW-1], ys_r};
    v_nxt    = {yc_r[PW-1], yc_r} - {xs_r[PW-1], xs_r};
    usq_full = u_r * u_r;
    vsq_full = v_r * v_r;
    usq_nxt  = usq_full[SQ_W-1:0];
    vsq_nxt  = vsq_full[SQ_W-1:0];
    ulo_nxt  = PP_W'(usq_r[LO_W-1:0]) * PP_W'(b2_r);
    uhi_nxt  = PP_W'(usq_r[SQ_W-1:LO_W]) * PP_W'(b2_r);
    vlo_nxt  = PP_W'(vsq_r[LO_W-1:0]) * PP_W'(a2_r);
    vhi_nxt  = PP_W'(vsq_r[SQ_W-1:LO_W]) * PP_W'(a2_r);
    l_nxt    = (L_W'(uhi_r) << LO_W) + L_W'(ulo_r) + (L_W'(vhi_r) << LO_W) + L_W'(vlo_r);
    d_nxt    = (D_W'(l_r) << TOL_BITS) - (D_W'(k_r) << (2 * FB + TOL_BITS));
    if ($signed(d_r) < $signed(nthr_r)) begin
      pos_nxt = POS_INTERIOR;
    end else if ($signed(d_r) > $signed(thr_r)) begin
      pos_nxt = POS_EXTERIOR;
    end else begin
      pos_nxt = POS_BOUNDARY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      xc_r  <= xc_nxt;
      ys_r  <= ys_nxt;
      yc_r  <= yc_nxt;
      xs_r  <= xs_nxt;
      u_r   <= u_nxt;
      v_r   <= v_nxt;
      usq_r <= usq_nxt;
      vsq_r <= vsq_nxt;
      ulo_r <= ulo_nxt;
      uhi_r <= uhi_nxt;
      vlo_r <= vlo_nxt;
      vhi_r <= vhi_nxt;
      l_r   <= l_nxt;
      d_r   <= d_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign out_position = pos_r;

endmodule

FILE: hdl/epc_checker.sv
module epc_checker
  import epc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_position
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position))
    else $error("stalled result word changed");

  a_pos_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position == POS_INTERIOR || out_position == POS_BOUNDARY ||
                   out_position == POS_EXTERIOR))
    else $error("result position code out of range");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_reset_drop: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word survived reset");

endmodule

bind ellipse_point_classifier epc_checker u_epc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_position (out_position)
);
